/* rtl/bbe_pkg.sv */
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared widths, register codes and controller/datapath interface structs
// for the box blur block.
// ----------------------------------------------------------------------------
package bbe_pkg;

  // store geometry and radius ceiling, fixed by the coordinate and register widths
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 15;

  localparam int NUM_CH  = 4;
  localparam int CH_W    = 16;
  localparam int PIX_W   = NUM_CH * CH_W;
  localparam int COORD_W = 8;
  localparam int DIM_W   = 9;
  localparam int RAD_W   = 4;
  localparam int SPAN_W  = 5;                  // up to 2*15+1 = 31
  localparam int CNT_W   = 2 * SPAN_W;         // up to 961
  localparam int SUM_W   = CH_W + CNT_W;       // 961 * 65535 fits
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_WIDTH   = 2'd1;
  localparam logic [1:0] REG_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_SIXTEEN = 2'd3;

  // effective (clamped) configuration
  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             sixteen;
  } cfg_t;

  typedef struct packed {
    logic busy;        // input side held off
    logic setup;       // compute window bounds
    logic scan_init;   // load counters, clear sums
    logic rd_en;       // read one store word, step counters
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic nc;          // not computed
    logic scan_last;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/bbe_div.sv */
// ----------------------------------------------------------------------------
// bbe_div
// Four-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module bbe_div import bbe_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [NUM_CH-1:0][SUM_W-1:0]   dividend,
  input  logic [CNT_W-1:0]               divisor,
  output logic [NUM_CH-1:0][SUM_W-1:0]   quotient,
  output logic                           busy
);

  logic [NUM_CH-1:0][SUM_W-1:0] quo, quo_next;
  logic [NUM_CH-1:0][CNT_W-1:0] rem, rem_next;
  logic [NUM_CH-1:0][CNT_W:0]   rem_sh;
  logic [NUM_CH-1:0]            fits;
  logic [CNT_W-1:0]             den;
  logic [STEP_W-1:0]            step;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      rem_sh[k]   = {rem[k], quo[k][SUM_W-1]};
      fits[k]     = rem_sh[k] >= {1'b0, den};
      rem_next[k] = fits[k] ? CNT_W'(rem_sh[k] - {1'b0, den}) : rem_sh[k][CNT_W-1:0];
      quo_next[k] = {quo[k][SUM_W-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      den  <= divisor;
      step <= STEP_W'(SUM_W - 1);
    end else if (busy) begin
      quo  <= quo_next;
      rem  <= rem_next;
      step <= step - 1'b1;
    end
  end

  assign quotient = quo;

endmodule

/* rtl/bbe_dp.sv */
// ----------------------------------------------------------------------------
// bbe_dp
// Datapath: image store, window bounds, scan counters, channel sums,
// divider and output register.
// ----------------------------------------------------------------------------
module bbe_dp import bbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic               wr_en,
  input  logic               qry_en,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [CH_W-1:0]    in_blue,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_alpha,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    out_blue,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_alpha,
  output logic               not_computed
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] q;
  logic             acc_pend;

  logic [COORD_W-1:0] col_q, row_q;
  logic [DIM_W-1:0]   x0_q, y0_q, x1m_q, y1m_q, cx, cy;
  logic               nc_q;
  logic [CNT_W-1:0]   count_q;
  logic [NUM_CH-1:0][SUM_W-1:0] sum, quot;

  // window bounds from the latched query
  logic [DIM_W-1:0]  rad9, x0, y0, xe, ye, x1, y1;
  logic [SPAN_W-1:0] span_x, span_y;
  logic              nc_calc;

  always_comb begin
    rad9    = {{(DIM_W-RAD_W){1'b0}}, cfg.radius};
    x0      = ({1'b0, col_q} >= rad9) ? {1'b0, col_q} - rad9 : '0;
    y0      = ({1'b0, row_q} >= rad9) ? {1'b0, row_q} - rad9 : '0;
    xe      = {1'b0, col_q} + rad9 + 1'b1;
    ye      = {1'b0, row_q} + rad9 + 1'b1;
    x1      = (xe > cfg.width)  ? cfg.width  : xe;
    y1      = (ye > cfg.height) ? cfg.height : ye;
    span_x  = SPAN_W'(x1 - x0);
    span_y  = SPAN_W'(y1 - y0);
    nc_calc = ({1'b0, col_q} >= cfg.width) || ({1'b0, row_q} >= cfg.height) ||
              ((cfg.radius != '0) &&
               (cfg.width <= {{(DIM_W-RAD_W-1){1'b0}}, cfg.radius, 1'b1}));
  end

  always_ff @(posedge clk) begin
    if (qry_en) begin
      col_q <= col;
      row_q <= row;
    end
    if (cmd.setup) begin
      x0_q    <= x0;
      y0_q    <= y0;
      x1m_q   <= x1 - 1'b1;
      y1m_q   <= y1 - 1'b1;
      nc_q    <= nc_calc;
      count_q <= span_x * span_y;
    end
    if (cmd.scan_init) begin
      cx <= x0_q;
      cy <= y0_q;
    end else if (cmd.rd_en) begin
      if (cx == x1m_q) begin
        cx <= x0_q;
        cy <= cy + 1'b1;
      end else begin
        cx <= cx + 1'b1;
      end
    end
  end

  // store: write port for source pixels, registered read for the scan
  logic             wr_ok;
  logic [ADDR_W-1:0] waddr, raddr;

  assign wr_ok = wr_en && (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
  assign waddr = ADDR_W'(32'(row) * MAX_WIDTH + 32'(col));
  assign raddr = ADDR_W'(32'(cy) * MAX_WIDTH + 32'(cx));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= {in_alpha, in_red, in_green, in_blue};
    end
    if (cmd.rd_en) begin
      q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sum <= '0;
    end else if (acc_pend) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (cfg.sixteen) begin
          sum[k] <= sum[k] + SUM_W'(q[CH_W*k +: CH_W]);
        end else begin
          sum[k] <= sum[k] + SUM_W'(q[CH_W*k +: 8]);
        end
      end
    end
  end

  logic div_busy;

  bbe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum),
    .divisor  (count_q),
    .quotient (quot),
    .busy     (div_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      not_computed <= nc_q;
      out_blue     <= nc_q ? '0 : quot[0][CH_W-1:0];
      out_green    <= nc_q ? '0 : quot[1][CH_W-1:0];
      out_red      <= nc_q ? '0 : quot[2][CH_W-1:0];
      out_alpha    <= nc_q ? '0 : quot[3][CH_W-1:0];
    end
  end

  assign status.nc        = nc_q;
  assign status.scan_last = (cx == x1m_q) && (cy == y1m_q);
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

/* rtl/bbe_ctrl.sv */
// ----------------------------------------------------------------------------
// bbe_ctrl
// Query sequencer: bounds, window scan, drain, divide, hand-off.
// ----------------------------------------------------------------------------
module bbe_ctrl import bbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       qry_en,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SETUP  = 8'b0000_0010,
    S_CHECK  = 8'b0000_0100,
    S_SCAN   = 8'b0000_1000,
    S_DRAIN  = 8'b0001_0000,
    S_DIVGO  = 8'b0010_0000,
    S_DIVIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.busy   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (qry_en) state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.scan_init = 1'b1;
        state_next    = status.nc ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (status.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DIVGO;
      end
      S_DIVGO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (!status.div_busy) state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/box_blur_edge_clipped_top.sv */
// ----------------------------------------------------------------------------
// box_blur_edge_clipped_top
// Box mean blur over a stored four-channel image with edge-clipped window.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              word
//  -------  ---------  ---------------------  -------------------------------
//  in       sink       in_valid / in_stall    kind, col, row, in_* channels
//  out      source     out_valid / out_stall  out_* channels, not_computed
//  cfg      APB slave  psel/penable/pready    radius, width, height, depth
//
//  A write word never stalls the input; writes keep flowing while a result
//  waits in the output register. A query reads the N pixels of its clipped
//  window (N at most 961) from the store, one store read per cycle, then
//  runs the bit-serial divider, one quotient bit at a time. Window or
//  out-of-image rejects skip the store reads and the divider.
//  in_stall is high from the cycle after a query is taken until its result
//  is loaded into the output register; a stalled output holds the sequencer.
//  Reset is synchronous; the image store is not cleared.
//
module box_blur_edge_clipped_top import bbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [CH_W-1:0]    in_blue,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_alpha,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CH_W-1:0]    out_blue,
  output logic [CH_W-1:0]    out_green,
  output logic [CH_W-1:0]    out_red,
  output logic [CH_W-1:0]    out_alpha,
  output logic               not_computed,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // --- configuration registers -------------------------------------------
  logic [RAD_W-1:0] radius;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             sixteen_bit;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= RAD_W'(3);
      image_width  <= DIM_W'(256);
      image_height <= DIM_W'(256);
      sixteen_bit  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RADIUS:  radius       <= pwdata[RAD_W-1:0];
        REG_WIDTH:   image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:  image_height <= pwdata[DIM_W-1:0];
        REG_SIXTEEN: sixteen_bit  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:  prdata = 32'(radius);
      REG_WIDTH:   prdata = 32'(image_width);
      REG_HEIGHT:  prdata = 32'(image_height);
      REG_SIXTEEN: prdata = 32'(sixteen_bit);
      default:     prdata = '0;
    endcase
  end

  // clamped view: zero size acts as one, oversize saturates to the store
  cfg_t cfg;

  always_comb begin
    cfg.radius  = (32'(radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : radius;
    if (image_width == '0) begin
      cfg.width = DIM_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      cfg.width = DIM_W'(MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height == '0) begin
      cfg.height = DIM_W'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      cfg.height = DIM_W'(MAX_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.sixteen = sixteen_bit;
  end

  // --- input acceptance ----------------------------------------------------
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_take;
  logic       wr_en;
  logic       qry_en;

  assign in_stall = cmd.busy;
  assign in_take  = in_valid && !in_stall;
  assign wr_en    = in_take && !kind;
  assign qry_en   = in_take && kind;

  bbe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .qry_en (qry_en),
    .status (status),
    .cmd    (cmd)
  );

  bbe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .wr_en        (wr_en),
    .qry_en       (qry_en),
    .col          (col),
    .row          (row),
    .in_blue      (in_blue),
    .in_green     (in_green),
    .in_red       (in_red),
    .in_alpha     (in_alpha),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_blue     (out_blue),
    .out_green    (out_green),
    .out_red      (out_red),
    .out_alpha    (out_alpha),
    .not_computed (not_computed)
  );

endmodule

/* rtl/bbe_checker.sv */
// ----------------------------------------------------------------------------
// bbe_checker
// Port-level assertions for the box blur block, bound to the top level.
// ----------------------------------------------------------------------------
module bbe_checker import bbe_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               kind,
  input logic               out_valid,
  input logic               out_stall,
  input logic [CH_W-1:0]    out_blue,
  input logic [CH_W-1:0]    out_green,
  input logic [CH_W-1:0]    out_red,
  input logic [CH_W-1:0]    out_alpha,
  input logic               not_computed
);

  // a taken query holds off the input side next cycle
  a_query_stalls: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && kind |=> in_stall)
    else $error("query taken but input not held off");

  // a pixel write never stalls the following word
  a_write_flows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !kind |=> !in_stall)
    else $error("pixel write stalled the input");

  // rejected result carries zero channels
  a_nc_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && not_computed |->
      out_blue == '0 && out_green == '0 && out_red == '0 && out_alpha == '0)
    else $error("not_computed result with nonzero channels");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red) &&
      $stable(out_alpha) && $stable(not_computed))
    else $error("stalled result word changed");

endmodule

bind box_blur_edge_clipped_top bbe_checker u_bbe_checker (.*);

/* tb/bbe_tb_pkg.sv */
// ----------------------------------------------------------------------------
// bbe_tb_pkg
// Word kinds, store geometry and the result record shared by the box blur
// testbench and its checker.
// ----------------------------------------------------------------------------
package bbe_tb_pkg;

  import bbe_pkg::*;

  localparam int IMG_MAX_W = 256;
  localparam int IMG_MAX_H = 256;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } word_kind_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] alpha;
    logic            nc;
  } blur_result_t;

endpackage

/* tb/blur_checker.sv */
// ----------------------------------------------------------------------------
// blur_checker
// Passive watcher for the box blur block: shadows the register file and the
// image store, computes the clipped window mean of every accepted query and
// matches it against the result words in order.
// ----------------------------------------------------------------------------
module blur_checker
  import bbe_pkg::*;
  import bbe_tb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               kind,
  input  logic [COORD_W-1:0] col,
  input  logic [COORD_W-1:0] row,
  input  logic [CH_W-1:0]    in_blue,
  input  logic [CH_W-1:0]    in_green,
  input  logic [CH_W-1:0]    in_red,
  input  logic [CH_W-1:0]    in_alpha,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CH_W-1:0]    out_blue,
  input  logic [CH_W-1:0]    out_green,
  input  logic [CH_W-1:0]    out_red,
  input  logic [CH_W-1:0]    out_alpha,
  input  logic               not_computed,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 results_done,
  output int                 waiting
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PIX_W-1:0] pixel_mem [0:IMG_MAX_W*IMG_MAX_H-1];
  logic [RAD_W-1:0] cfg_radius;
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic             cfg_sixteen;
  blur_result_t     pending_means [$];

  initial begin
    mismatches   = 0;
    results_done = 0;
    waiting      = 0;
  end

  // mean over the edge-clipped window, per the current register values
  function automatic blur_result_t window_mean(int unsigned c, int unsigned r);
    int unsigned w, h, rad, x0, x1, y0, y1, cnt;
    longint unsigned acc [NUM_CH];
    logic [CH_W-1:0] ch [NUM_CH];
    logic [CH_W-1:0] mask;
    logic [PIX_W-1:0] px;
    blur_result_t res;
    res  = '0;
    w    = (cfg_width == 0) ? 1 : ((cfg_width > IMG_MAX_W) ? IMG_MAX_W : cfg_width);
    h    = (cfg_height == 0) ? 1 : ((cfg_height > IMG_MAX_H) ? IMG_MAX_H : cfg_height);
    rad  = cfg_radius;
    mask = cfg_sixteen ? 16'hFFFF : 16'h00FF;
    for (int k = 0; k < NUM_CH; k++) begin
      ch[k]  = '0;
      acc[k] = 0;
    end
    if (c >= w || r >= h) begin
      res.nc = 1'b1;
    end else if (rad == 0) begin
      px = pixel_mem[r*IMG_MAX_W + c];
      for (int k = 0; k < NUM_CH; k++) ch[k] = px[k*CH_W +: CH_W] & mask;
    end else if (w <= 2*rad + 1) begin
      res.nc = 1'b1;
    end else begin
      x0 = (c >= rad) ? c - rad : 0;
      y0 = (r >= rad) ? r - rad : 0;
      x1 = (c + rad + 1 > w) ? w : c + rad + 1;
      y1 = (r + rad + 1 > h) ? h : r + rad + 1;
      for (int y = y0; y < y1; y++) begin
        for (int x = x0; x < x1; x++) begin
          px = pixel_mem[y*IMG_MAX_W + x];
          for (int k = 0; k < NUM_CH; k++) acc[k] += px[k*CH_W +: CH_W] & mask;
        end
      end
      cnt = (x1 - x0) * (y1 - y0);
      for (int k = 0; k < NUM_CH; k++) ch[k] = CH_W'(acc[k] / cnt);
    end
    res.blue  = ch[0];
    res.green = ch[1];
    res.red   = ch[2];
    res.alpha = ch[3];
    return res;
  endfunction

  task automatic check_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    blur_result_t want;
    if (rst) begin
      cfg_radius  = 4'd3;
      cfg_width   = 9'd256;
      cfg_height  = 9'd256;
      cfg_sixteen = 1'b0;
      pending_means.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RADIUS:  cfg_radius  = pwdata[RAD_W-1:0];
          REG_WIDTH:   cfg_width   = pwdata[DIM_W-1:0];
          REG_HEIGHT:  cfg_height  = pwdata[DIM_W-1:0];
          REG_SIXTEEN: cfg_sixteen = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (kind == KIND_WRITE)
          pixel_mem[{row, col}] = {in_alpha, in_red, in_green, in_blue};
        else
          pending_means.push_back(window_mean(col, row));
      end
      if (out_valid && !out_stall) begin
        if (pending_means.size() == 0) begin
          $error("result word with no query outstanding");
          mismatches++;
        end else begin
          want = pending_means.pop_front();
          check_field("out_blue",     want.blue,  out_blue);
          check_field("out_green",    want.green, out_green);
          check_field("out_red",      want.red,   out_red);
          check_field("out_alpha",    want.alpha, out_alpha);
          check_field("not_computed", CH_W'(want.nc), CH_W'(not_computed));
        end
        results_done++;
      end
    end
    waiting = pending_means.size();
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for box_blur_edge_clipped_top. Directed words cover the
// window corners, out-of-image queries, radius zero and the narrow-image case;
// random phases then sweep register settings (including width/height extremes
// and out-of-range values) under varying sender gaps and receiver stalls.
// Every query's window is written first, so no unwritten pixel is ever read.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbe_pkg::*;
  import bbe_tb_pkg::*;

  localparam int RANDOM_WORDS = 600;
  localparam int SETTLE       = 60;        // margin for trailing write words and rejects
  // worst case: every query a full 961-pixel window plus divider, long stalls
  localparam int CYCLE_LIMIT  = 10_000_000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               kind = KIND_WRITE;
  logic [COORD_W-1:0] col = '0;
  logic [COORD_W-1:0] row = '0;
  logic [CH_W-1:0]    in_blue = '0;
  logic [CH_W-1:0]    in_green = '0;
  logic [CH_W-1:0]    in_red = '0;
  logic [CH_W-1:0]    in_alpha = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CH_W-1:0]    out_blue;
  logic [CH_W-1:0]    out_green;
  logic [CH_W-1:0]    out_red;
  logic [CH_W-1:0]    out_alpha;
  logic               not_computed;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int mismatches, results_done, waiting;

  // driver-side bookkeeping
  int sender_idle_pct    = 0;
  int receiver_stall_pct = 0;
  int words_sent         = 0;
  int queries_sent       = 0;
  int cycle_count        = 0;
  bit written [0:IMG_MAX_W*IMG_MAX_H-1];

  // effective geometry, mirrored so queries land where the window is written
  int cur_w = IMG_MAX_W;
  int cur_h = IMG_MAX_H;
  int cur_rad = 3;

  always #2 clk = ~clk;

  box_blur_edge_clipped_top u_top (
    .clk, .rst,
    .in_valid, .in_stall, .kind, .col, .row,
    .in_blue, .in_green, .in_red, .in_alpha,
    .out_valid, .out_stall, .out_blue, .out_green, .out_red, .out_alpha,
    .not_computed,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  blur_checker u_check (
    .clk, .rst,
    .in_valid, .in_stall, .kind, .col, .row,
    .in_blue, .in_green, .in_red, .in_alpha,
    .out_valid, .out_stall, .out_blue, .out_green, .out_red, .out_alpha,
    .not_computed,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatches, .results_done, .waiting
  );

  // receiver backpressure, redrawn every cycle
  always @(posedge clk)
    out_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // biased toward all-zero, all-one and byte-boundary patterns
  function automatic logic [CH_W-1:0] pick_chan();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'hFF00;
      default: return CH_W'($urandom);
    endcase
  endfunction

  // one word on the input channel; valid stays up across back-to-back words
  task automatic send_word(word_kind_t k, int c, int r, logic [CH_W-1:0] b,
                           logic [CH_W-1:0] g, logic [CH_W-1:0] rd,
                           logic [CH_W-1:0] a);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    col      <= c[COORD_W-1:0];
    row      <= r[COORD_W-1:0];
    in_blue  <= b;
    in_green <= g;
    in_red   <= rd;
    in_alpha <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    if (k == KIND_QUERY) queries_sent++;
    else written[r*IMG_MAX_W + c] = 1'b1;
  endtask

  task automatic write_pixel(int c, int r);
    send_word(KIND_WRITE, c, r, pick_chan(), pick_chan(), pick_chan(), pick_chan());
  endtask

  // fill any unwritten pixel of the clipped window, then ask for the mean
  task automatic query(int c, int r);
    int x0, x1, y0, y1;
    if (c < cur_w && r < cur_h) begin
      x0 = (c > cur_rad) ? c - cur_rad : 0;
      y0 = (r > cur_rad) ? r - cur_rad : 0;
      x1 = (c + cur_rad + 1 > cur_w) ? cur_w : c + cur_rad + 1;
      y1 = (r + cur_rad + 1 > cur_h) ? cur_h : r + cur_rad + 1;
      for (int y = y0; y < y1; y++)
        for (int x = x0; x < x1; x++)
          if (!written[y*IMG_MAX_W + x]) write_pixel(x, y);
    end
    // channel fields are don't-care on a query but still exercised
    send_word(KIND_QUERY, c, r, pick_chan(), pick_chan(), pick_chan(), pick_chan());
  endtask

  // wait for every result, then let trailing write words retire
  task automatic drain();
    in_valid <= 1'b0;
    while (results_done != queries_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // setup + access cycle; the write lands on the edge where pready is seen.
  // psel stays up so back-to-back writes chain; the caller closes the bus.
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  // only called with the block idle; raw values may be out of range on purpose
  task automatic configure(int rad, int w_raw, int h_raw, bit sixteen);
    drain();
    reg_write(REG_RADIUS,  32'(rad));
    reg_write(REG_WIDTH,   32'(w_raw));
    reg_write(REG_HEIGHT,  32'(h_raw));
    reg_write(REG_SIXTEEN, 32'(sixteen));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_rad = rad;
    cur_w   = (w_raw == 0) ? 1 : ((w_raw > IMG_MAX_W) ? IMG_MAX_W : w_raw);
    cur_h   = (h_raw == 0) ? 1 : ((h_raw > IMG_MAX_H) ? IMG_MAX_H : h_raw);
  endtask

  initial begin
    int phase, sel, n, rad, w_raw, h_raw;
    int idx;
    bit sixteen;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: 4x3 image, radius 1, 16-bit channels
    configure(1, 4, 3, 1'b1);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 4; x++) begin
        idx = y*4 + x;
        send_word(KIND_WRITE, x, y, {CH_W{idx[0]}}, idx[1] ? 16'hFF00 : 16'h00FF,
                  CH_W'($urandom), 16'hFFFF - CH_W'(idx));
      end
    query(0, 0);        // top-left corner, 2x2 window
    query(3, 2);        // bottom-right corner
    query(1, 1);        // full 3x3 window
    query(2, 0);        // top edge
    query(4, 1);        // column past width
    query(0, 3);        // row past height
    query(255, 255);

    // radius zero passes pixels through; width register 0 acts as 1
    configure(0, 0, 3, 1'b0);
    query(0, 0);
    query(0, 2);
    query(1, 0);        // outside the one-pixel-wide image

    // window at least as wide as the image: not computed
    configure(2, 5, 3, 1'b1);
    query(1, 1);
    query(4, 2);

    // --- random phases
    phase = 0;
    while (words_sent < 24 + RANDOM_WORDS) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
      endcase

      // first few phases hit the register extremes, then mostly small images
      sel = (phase < 4) ? phase : $urandom_range(9);
      case (sel)
        0: begin          // full width, one or two rows, largest radius
          rad   = 15;
          w_raw = $urandom_range(1) ? IMG_MAX_W : $urandom_range(257, 511);
          h_raw = $urandom_range(2);
        end
        1: begin          // one column, full height
          rad   = $urandom_range(15);
          w_raw = $urandom_range(1);
          h_raw = $urandom_range(1) ? IMG_MAX_H : $urandom_range(257, 511);
        end
        2: begin
          rad   = 15;
          w_raw = $urandom_range(1, 12);
          h_raw = $urandom_range(1, 12);
        end
        3: begin
          rad   = 0;
          w_raw = $urandom_range(1, 12);
          h_raw = $urandom_range(1, 12);
        end
        default: begin
          rad   = $urandom_range(4);
          w_raw = $urandom_range(1, 12);
          h_raw = $urandom_range(1, 12);
        end
      endcase
      sixteen = $urandom_range(1);
      configure(rad, w_raw, h_raw, sixteen);

      n = $urandom_range(30, 70);
      repeat (n) begin
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(9) < 8)
            query($urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
          else
            query($urandom_range(255), $urandom_range(255));
        end else begin
          // writes outside the image in use still land in the store
          if ($urandom_range(9) < 7)
            write_pixel($urandom_range(cur_w - 1), $urandom_range(cur_h - 1));
          else
            write_pixel($urandom_range(255), $urandom_range(255));
        end
      end
      phase++;
    end

    drain();
    if (mismatches == 0 && waiting == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
